@@ sv/mlp_pkg.sv @@
//------------------------------------------------------------------------------
// mlp_pkg
// Shared types and constants of the metadata line parser.
//------------------------------------------------------------------------------
`default_nettype none
package mlp_pkg;
   localparam int NAME_MAX_DEFAULT = 4095;
   localparam int HASH_BYTES_DEFAULT = 32;

   localparam logic [1:0] KIND_NAME = 2'd0;
   localparam logic [1:0] KIND_NUM  = 2'd1;
   localparam logic [1:0] KIND_HASH = 2'd2;
   localparam logic [1:0] KIND_END  = 2'd3;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_SYN  = 2'd1;
   localparam logic [1:0] ST_LONG = 2'd2;

   localparam logic CSR_CHECKSUM = 1'b0;
   localparam logic CSR_HASHMODE = 1'b1;

   typedef enum logic [2:0] {
      PH_NAME, PH_NUM_FIRST, PH_NUM_REST, PH_HASH1, PH_MID, PH_HASH2, PH_END, PH_SKIP
   } phase_type;

   // One result word.
   typedef struct packed {
      logic [1:0]  kind;
      logic [11:0] index;
      logic [63:0] value;
      logic [1:0]  status;
      logic        hash_present;
      logic        last;
   } result_type;

   // Classified byte from the front end.
   typedef struct packed {
      logic [7:0] data;
      logic       is_digit;
      logic       is_hex;
      logic [3:0] nib;
      logic       is_nl;
      logic       is_space;
      logic       is_bslash;
      logic       is_sign;
      logic       is_zero;
   } class_type;
endpackage
`default_nettype wire

@@ sv/mlp_front.sv @@
//------------------------------------------------------------------------------
// mlp_front
// Accepts input bytes, classifies them and queues them for the back end.
//------------------------------------------------------------------------------
`default_nettype none
module mlp_front import mlp_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   output logic            full,
   input  wire logic [7:0] line_byte,
   output logic            q_valid,
   output class_type       q_word,
   input  wire logic       q_take
);
   class_type cls;
   class_type buf_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic       acc;

   // Classify the byte.
   always_comb begin
      cls.data      = line_byte;
      cls.is_digit  = (line_byte >= 8'h30) && (line_byte <= 8'h39);
      cls.is_nl     = (line_byte == 8'h0a);
      cls.is_space  = (line_byte == 8'h20);
      cls.is_bslash = (line_byte == 8'h5c);
      cls.is_sign   = (line_byte == 8'h2b) || (line_byte == 8'h2d);
      cls.is_zero   = (line_byte == 8'h00);
      cls.is_hex    = 1'b1;
      cls.nib       = 4'd0;
      if (cls.is_digit) begin
         cls.nib = line_byte[3:0];
      end else if ((line_byte >= 8'h61 && line_byte <= 8'h66) ||
                   (line_byte >= 8'h41 && line_byte <= 8'h46)) begin
         cls.nib = line_byte[3:0] + 4'd9;
      end else begin
         cls.is_hex = 1'b0;
      end
   end

   // Two-entry queue.
   assign full    = cnt_ff[1];
   assign acc     = push && !full;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_word  = buf_ff[rp_ff];

   always_comb begin
      cnt_in = cnt_ff + {1'b0, acc} - {1'b0, q_take};
      wp_in  = wp_ff ^ acc;
      rp_in  = rp_ff ^ q_take;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
      end
      if (acc) begin
         buf_ff[wp_ff] <= cls;
      end
   end
endmodule
`default_nettype wire

@@ sv/mlp_back.sv @@
//------------------------------------------------------------------------------
// mlp_back
// Line state machine; emits up to two result words per byte into a queue.
//------------------------------------------------------------------------------
`default_nettype none
module mlp_back import mlp_pkg::*; #(
   parameter int NAME_MAX_BYTES = NAME_MAX_DEFAULT,
   parameter int HASH_BYTES = HASH_BYTES_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  checksum_required,
   input  wire logic  hash_file_mode,
   input  wire logic  q_valid,
   input  class_type  q_word,
   output logic       q_take,
   output logic       empty,
   input  wire logic  pop,
   output result_type rsp
);
   localparam logic [6:0] HEX_LAST = 7'(2 * HASH_BYTES - 1);
   localparam logic [63:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] SMIN = 64'h8000_0000_0000_0000;
   localparam logic [63:0] ULIM = 64'h1999_9999_9999_9999;

   phase_type   ph_ff, ph_in;
   logic        esc_ff, esc_in;
   logic [12:0] nc_ff, nc_in;
   logic [3:0]  fn_ff, fn_in;
   logic [63:0] acc_ff, acc_in;
   logic        neg_ff, neg_in, dig_ff, dig_in, ovf_ff, ovf_in;
   logic [6:0]  hc_ff, hc_in;
   logic [3:0]  hn_ff, hn_in;
   logic [1:0]  err_ff, err_in;

   result_type  r0, r1, nv;
   logic        e0, e1;
   logic [63:0] x10, sum;
   logic        carry, mulovf;
   logic [3:0]  last_fn;

   // Output queue of four words.
   result_type  oq_ff [4];
   logic [2:0]  oc_ff, oc_in;
   logic [1:0]  ow_ff, or_ff;
   logic        opop;
   logic [1:0]  nput;

   assign empty  = (oc_ff == 3'd0);
   assign rsp    = oq_ff[or_ff];
   assign opop   = pop && !empty;
   assign q_take = q_valid && (oc_ff <= 3'd2);

   // Decimal step: acc * 10 + digit with overflow detection.
   always_comb begin
      x10 = {acc_ff[60:0], 3'b000} + {acc_ff[62:0], 1'b0};
      {carry, sum} = {1'b0, x10} + {61'd0, q_word.data[3:0]};
      mulovf = (acc_ff > ULIM) || carry;
   end

   // Signed or unsigned finished number.
   always_comb begin
      nv = '0;
      nv.kind  = KIND_NUM;
      nv.index = {8'd0, fn_ff};
      if (fn_ff == 4'd1 || fn_ff == 4'd4) begin
         nv.value = ovf_ff ? '1 : (neg_ff ? 64'd0 - acc_ff : acc_ff);
      end else if (!neg_ff) begin
         nv.value = (ovf_ff || acc_ff > SMAX) ? SMAX : acc_ff;
      end else begin
         nv.value = (ovf_ff || acc_ff > SMIN) ? SMIN : 64'd0 - acc_ff;
      end
   end

   // Line state machine.
   always_comb begin
      ph_in = ph_ff; esc_in = esc_ff; nc_in = nc_ff; fn_in = fn_ff;
      acc_in = acc_ff; neg_in = neg_ff; dig_in = dig_ff; ovf_in = ovf_ff;
      hc_in = hc_ff; hn_in = hn_ff; err_in = err_ff;
      r0 = '0; r1 = '0; e0 = 1'b0; e1 = 1'b0;
      last_fn = hash_file_mode ? 4'd7 : 4'd9;
      if (q_take) begin
         // The line end word; slot chosen below.
         r1.kind = KIND_END;
         r1.last = 1'b1;
         r1.status = ST_SYN;
         case (ph_ff)
            PH_NAME: begin
               if (q_word.is_nl) begin
                  e1 = 1'b1;
               end else if (esc_ff) begin
                  if (q_word.is_zero) begin
                     ph_in = PH_SKIP; err_in = ST_SYN;
                  end else if (nc_ff >= 13'(NAME_MAX_BYTES)) begin
                     ph_in = PH_SKIP; err_in = ST_LONG;
                  end else begin
                     e0 = 1'b1; r0.index = nc_ff[11:0];
                     r0.value = {56'd0, q_word.data};
                     nc_in = nc_ff + 13'd1; esc_in = 1'b0;
                  end
               end else if (q_word.is_space) begin
                  ph_in = PH_NUM_FIRST; fn_in = 4'd0;
                  acc_in = '0; neg_in = 1'b0; dig_in = 1'b0; ovf_in = 1'b0;
               end else if (nc_ff >= 13'(NAME_MAX_BYTES)) begin
                  ph_in = PH_SKIP; err_in = ST_LONG;
               end else if (q_word.is_zero) begin
                  ph_in = PH_SKIP; err_in = ST_SYN;
               end else if (q_word.is_bslash) begin
                  esc_in = 1'b1;
               end else begin
                  e0 = 1'b1; r0.index = nc_ff[11:0];
                  r0.value = {56'd0, q_word.data};
                  nc_in = nc_ff + 13'd1;
               end
            end
            PH_NUM_FIRST, PH_NUM_REST: begin
               if (q_word.is_digit) begin
                  if (!ovf_ff) begin
                     if (mulovf) ovf_in = 1'b1;
                     else acc_in = sum;
                  end
                  dig_in = 1'b1; ph_in = PH_NUM_REST;
               end else if (ph_ff == PH_NUM_FIRST && q_word.is_sign) begin
                  neg_in = q_word.data[2];
                  ph_in = PH_NUM_REST;
               end else if (q_word.is_space || q_word.is_nl) begin
                  if (!dig_ff) begin
                     if (q_word.is_nl) e1 = 1'b1;
                     else begin ph_in = PH_SKIP; err_in = ST_SYN; end
                  end else begin
                     e0 = 1'b1; r0 = nv;
                     if (fn_ff < last_fn) begin
                        if (q_word.is_nl) e1 = 1'b1;
                        else begin
                           fn_in = fn_ff + 4'd1; ph_in = PH_NUM_FIRST;
                           acc_in = '0; neg_in = 1'b0; dig_in = 1'b0; ovf_in = 1'b0;
                        end
                     end else if (q_word.is_nl) begin
                        e1 = 1'b1;
                        r1.status = checksum_required ? ST_SYN : ST_OK;
                     end else if (checksum_required || hash_file_mode) begin
                        ph_in = PH_HASH1; hc_in = '0;
                     end else begin
                        ph_in = PH_SKIP; err_in = ST_SYN;
                     end
                  end
               end else begin
                  ph_in = PH_SKIP; err_in = ST_SYN;
               end
            end
            PH_HASH1, PH_HASH2: begin
               if (q_word.is_nl) begin
                  e1 = 1'b1;
               end else if (!q_word.is_hex) begin
                  ph_in = PH_SKIP; err_in = ST_SYN;
               end else begin
                  if (!hc_ff[0]) hn_in = q_word.nib;
                  else begin
                     e0 = 1'b1; r0.kind = KIND_HASH;
                     r0.index = 12'((ph_ff == PH_HASH2) ? HASH_BYTES : 0) +
                                {6'd0, hc_ff[6:1]};
                     r0.value = {56'd0, hn_ff, q_word.nib};
                  end
                  hc_in = hc_ff + 7'd1;
                  if (hc_ff == HEX_LAST) begin
                     hc_in = '0;
                     ph_in = (ph_ff == PH_HASH1) ? PH_MID : PH_END;
                  end
               end
            end
            PH_MID: begin
               if (q_word.is_nl) e1 = 1'b1;
               else if (q_word.is_space) ph_in = PH_HASH2;
               else begin ph_in = PH_SKIP; err_in = ST_SYN; end
            end
            PH_END: begin
               if (q_word.is_nl) begin
                  e1 = 1'b1; r1.status = ST_OK; r1.hash_present = 1'b1;
               end else begin
                  ph_in = PH_SKIP; err_in = ST_SYN;
               end
            end
            default: begin
               if (q_word.is_nl) begin
                  e1 = 1'b1;
                  r1.status = (err_ff != 2'd0) ? err_ff : ST_SYN;
               end
            end
         endcase
         if (e1) begin
            ph_in = PH_NAME; esc_in = 1'b0; nc_in = '0; fn_in = '0;
            acc_in = '0; neg_in = 1'b0; dig_in = 1'b0; ovf_in = 1'b0;
            hc_in = '0; hn_in = '0; err_in = '0;
         end
      end
      nput = {1'b0, e0} + {1'b0, e1};
      oc_in = oc_ff + {1'b0, nput} - {2'd0, opop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= PH_NAME; esc_ff <= 1'b0; nc_ff <= '0; fn_ff <= '0;
         neg_ff <= 1'b0; dig_ff <= 1'b0; ovf_ff <= 1'b0; acc_ff <= '0;
         hc_ff <= '0; hn_ff <= '0; err_ff <= '0;
         oc_ff <= '0; ow_ff <= '0; or_ff <= '0;
      end else begin
         ph_ff <= ph_in; esc_ff <= esc_in; nc_ff <= nc_in; fn_ff <= fn_in;
         neg_ff <= neg_in; dig_ff <= dig_in; ovf_ff <= ovf_in; acc_ff <= acc_in;
         hc_ff <= hc_in; hn_ff <= hn_in; err_ff <= err_in;
         oc_ff <= oc_in; ow_ff <= ow_ff + nput; or_ff <= or_ff + {1'b0, opop};
      end
      if (e0) begin
         oq_ff[ow_ff] <= r0;
      end
      if (e1) begin
         oq_ff[ow_ff + {1'b0, e0}] <= r1;
      end
   end
endmodule
`default_nettype wire

@@ sv/metadata_line_parser_core.sv @@
//------------------------------------------------------------------------------
// metadata_line_parser_core
// Byte-stream parser for metadata lines: filename, decimal fields, hashes.
//------------------------------------------------------------------------------
// A byte is registered in the front queue; the back end takes it from there and
// registers its result words in the result queue that drives the result ports.
// Throughput: one byte per cycle while the back end's four-word result queue
// has room for two words (a byte gives up to two words); else the byte waits.
// Reset: synchronous; clears both queues, the line state and both registers.
`default_nettype none
module metadata_line_parser_core import mlp_pkg::*; #(
   parameter int NAME_MAX_BYTES = NAME_MAX_DEFAULT,
   parameter int HASH_BYTES = HASH_BYTES_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic [7:0]  req_line_byte,
   output logic             empty,
   input  wire logic        pop,
   output logic [1:0]       rsp_item_kind,
   output logic [11:0]      rsp_item_index,
   output logic [63:0]      rsp_item_value,
   output logic [1:0]       rsp_line_status,
   output logic             rsp_hash_present,
   output logic             rsp_last_of_line,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic        csr_data
);
   logic       cks_ff, hfm_ff;
   logic       q_valid, q_take;
   class_type  q_word;
   result_type rsp;

   // Configuration registers; indexes beyond the list are ignored.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         cks_ff <= 1'b0;
         hfm_ff <= 1'b0;
      end else if (csr_valid) begin
         if (csr_index == CSR_CHECKSUM) cks_ff <= csr_data;
         if (csr_index == CSR_HASHMODE) hfm_ff <= csr_data;
      end
   end

   mlp_front u_front (
      .clock, .reset, .push, .full, .line_byte(req_line_byte),
      .q_valid, .q_word, .q_take
   );

   mlp_back #(.NAME_MAX_BYTES(NAME_MAX_BYTES), .HASH_BYTES(HASH_BYTES)) u_back (
      .clock, .reset, .checksum_required(cks_ff), .hash_file_mode(hfm_ff),
      .q_valid, .q_word, .q_take, .empty, .pop, .rsp
   );

   assign rsp_item_kind    = rsp.kind;
   assign rsp_item_index   = rsp.index;
   assign rsp_item_value   = rsp.value;
   assign rsp_line_status  = rsp.status;
   assign rsp_hash_present = rsp.hash_present;
   assign rsp_last_of_line = rsp.last;

   // A line end word always carries the last flag.
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_item_kind == KIND_END |-> rsp_last_of_line)
      else $error("line end without last flag");
   // Hash flag only on an ok line end.
   a_hash_ok: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_hash_present |-> rsp_line_status == ST_OK && rsp_last_of_line)
      else $error("hash flag on bad word");
   // A word that is not taken stays.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty && $stable(rsp_item_value))
      else $error("result changed while stalled");
endmodule
`default_nettype wire

@@ bench/tb_metadata_line_parser_core.sv @@
//------------------------------------------------------------------------------
// tb_metadata_line_parser_core
// Self-checking bench for the metadata line parser. Directed lines exercise
// names, number limits, hashes and error paths; random well-formed and broken
// lines follow under several register settings. A behavioral line parser in
// the bench predicts each result word, and results are compared in order.
//------------------------------------------------------------------------------
`default_nettype none
module tb_metadata_line_parser_core;
   import mlp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NAME_MAX = NAME_MAX_DEFAULT;
   localparam int HBYTES = HASH_BYTES_DEFAULT;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic full;
   logic [7:0] req_line_byte = 8'd0;
   logic empty;
   logic pop = 1'b0;
   logic [1:0] rsp_item_kind;
   logic [11:0] rsp_item_index;
   logic [63:0] rsp_item_value;
   logic [1:0] rsp_line_status;
   logic rsp_hash_present;
   logic rsp_last_of_line;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic csr_index = 1'b0;
   logic csr_data = 1'b0;

   metadata_line_parser_core dut (.*);

   always #5 clock = ~clock;

   // Predictor state: registers and line state.
   logic chk_req, hash_mode;
   phase_type ph;
   logic esc;
   int unsigned name_cnt, fld, hexc;
   logic [63:0] acc;
   logic neg, dig, ovf;
   logic [3:0] hi_nib;
   logic [1:0] err;

   result_type expected_words[$];
   int mismatches = 0;
   int words_seen = 0;
   int lines_seen = 0;
   int bytes_sent = 0;
   logic [1:0] last_status = 2'd0;

   function automatic result_type mk(logic [1:0] k, int unsigned idx, logic [63:0] v,
                                     logic [1:0] st, logic hp, logic l);
      result_type r;
      r.kind = k; r.index = idx[11:0]; r.value = v; r.status = st;
      r.hash_present = hp; r.last = l;
      return r;
   endfunction

   function automatic void clear_line();
      ph = PH_NAME; esc = 0; name_cnt = 0; fld = 0; acc = '0; neg = 0; dig = 0;
      ovf = 0; hexc = 0; hi_nib = 0; err = ST_OK;
   endfunction

   function automatic void line_done(logic [1:0] st, logic hp);
      expected_words.push_back(mk(KIND_END, 0, 64'd0, st, hp, 1'b1));
      clear_line();
   endfunction

   function automatic logic [63:0] field_value();
      logic [63:0] smax, smin;
      smax = 64'h7FFF_FFFF_FFFF_FFFF;
      smin = 64'h8000_0000_0000_0000;
      if (fld == 1 || fld == 4) begin
         if (ovf) return '1;
         return neg ? -acc : acc;
      end
      if (!neg) return (ovf || acc > smax) ? smax : acc;
      if (ovf || acc > smin) return smin;
      return -acc;
   endfunction

   function automatic int hex_of(logic [7:0] b);
      if (b >= "0" && b <= "9") return b - "0";
      if (b >= "a" && b <= "f") return b - "a" + 10;
      if (b >= "A" && b <= "F") return b - "A" + 10;
      return -1;
   endfunction

   // Advance the line parser by one byte and queue the words it yields.
   function automatic void parse_byte(logic [7:0] b);
      logic nl;
      int v;
      int unsigned last_fld, idx;
      logic [63:0] d;
      nl = (b == 8'd10);
      case (ph)
         PH_NAME: begin
            if (nl) begin line_done(ST_SYN, 0); return; end
            if (esc) begin
               if (b == 0) begin err = ST_SYN; ph = PH_SKIP; end
               else if (name_cnt >= NAME_MAX) begin err = ST_LONG; ph = PH_SKIP; end
               else begin
                  expected_words.push_back(mk(KIND_NAME, name_cnt, {56'd0, b}, ST_OK, 0, 0));
                  name_cnt++; esc = 0;
               end
            end else if (b == " ") begin
               ph = PH_NUM_FIRST; fld = 0; acc = 0; neg = 0; dig = 0; ovf = 0;
            end else if (name_cnt >= NAME_MAX) begin err = ST_LONG; ph = PH_SKIP;
            end else if (b == 0) begin err = ST_SYN; ph = PH_SKIP;
            end else if (b == "\\") esc = 1;
            else begin
               expected_words.push_back(mk(KIND_NAME, name_cnt, {56'd0, b}, ST_OK, 0, 0));
               name_cnt++;
            end
         end
         PH_NUM_FIRST, PH_NUM_REST: begin
            if (b >= "0" && b <= "9") begin
               d = b - "0";
               if (!ovf) begin
                  if (acc > (64'hFFFF_FFFF_FFFF_FFFF - d) / 10) ovf = 1;
                  else acc = acc * 10 + d;
               end
               dig = 1; ph = PH_NUM_REST;
            end else if (ph == PH_NUM_FIRST && (b == "+" || b == "-")) begin
               neg = (b == "-"); ph = PH_NUM_REST;
            end else if (b == " " || nl) begin
               last_fld = hash_mode ? 7 : 9;
               if (!dig) begin
                  if (nl) begin line_done(ST_SYN, 0); return; end
                  err = ST_SYN; ph = PH_SKIP; return;
               end
               expected_words.push_back(mk(KIND_NUM, fld, field_value(), ST_OK, 0, 0));
               if (fld < last_fld) begin
                  if (nl) begin line_done(ST_SYN, 0); return; end
                  fld++; acc = 0; neg = 0; dig = 0; ovf = 0; ph = PH_NUM_FIRST;
               end else if (nl) line_done(chk_req ? ST_SYN : ST_OK, 0);
               else if (chk_req || hash_mode) begin ph = PH_HASH1; hexc = 0; end
               else begin err = ST_SYN; ph = PH_SKIP; end
            end else begin err = ST_SYN; ph = PH_SKIP; end
         end
         PH_HASH1, PH_HASH2: begin
            if (nl) begin line_done(ST_SYN, 0); return; end
            v = hex_of(b);
            if (v < 0) begin err = ST_SYN; ph = PH_SKIP; return; end
            if (hexc % 2 == 0) hi_nib = v[3:0];
            else begin
               idx = (ph == PH_HASH2 ? HBYTES : 0) + hexc / 2;
               expected_words.push_back(mk(KIND_HASH, idx, {56'd0, hi_nib, v[3:0]},
                                           ST_OK, 0, 0));
            end
            hexc++;
            if (hexc >= 2 * HBYTES) begin
               hexc = 0; ph = (ph == PH_HASH1) ? PH_MID : PH_END;
            end
         end
         PH_MID: begin
            if (nl) begin line_done(ST_SYN, 0); return; end
            if (b == " ") ph = PH_HASH2;
            else begin err = ST_SYN; ph = PH_SKIP; end
         end
         PH_END: begin
            if (nl) begin line_done(ST_OK, 1); return; end
            err = ST_SYN; ph = PH_SKIP;
         end
         default: if (nl) line_done(err != ST_OK ? err : ST_SYN, 0);
      endcase
   endfunction

   // Sender with bursts and gaps; the predictor runs on each accepted byte.
   // Push stays high between bytes of a burst and drops only in a gap or a drain.
   int burst_left = 0;
   task automatic send_byte(logic [7:0] b);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         if ($urandom_range(0, 3) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
      end
      burst_left--;
      push <= 1'b1;
      req_line_byte <= b;
      @(posedge clock);
      while (full) @(posedge clock);
      parse_byte(b);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   task automatic drain();
      push <= 1'b0;
      while (expected_words.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_reg(logic idx, logic val);
      csr_valid <= 1'b1; csr_index <= idx; csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_CHECKSUM) chk_req = val; else hash_mode = val;
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Receiver stalls on its own pattern; each popped word is checked in order.
   int stall_mode = 0;
   always @(negedge clock) begin
      if ($urandom_range(0, 99) == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
         0: pop <= 1'b1;
         1: pop <= ($urandom_range(0, 3) != 0);
         default: pop <= ($urandom_range(0, 3) == 0);
      endcase
   end

   always @(posedge clock) begin
      result_type got, want;
      if (!reset && pop && !empty) begin
         got = mk(rsp_item_kind, rsp_item_index, rsp_item_value, rsp_line_status,
                  rsp_hash_present, rsp_last_of_line);
         words_seen++;
         if (got.last) begin
            lines_seen++;
            last_status = got.status;
         end
         if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word %p", got);
         end else begin
            want = expected_words.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
            end
         end
      end
   end

   // Random pieces of a line.
   function automatic string rand_name();
      string s;
      int n;
      byte c;
      s = "";
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++) begin
         c = $urandom_range(33, 126);
         if ($urandom_range(0, 7) == 0) s = {s, "\\", byte'($urandom_range(1, 255))};
         else if (c != "\\") s = {s, c};
         else s = {s, "a"};
      end
      return s;
   endfunction

   function automatic string rand_num();
      string s;
      int n;
      case ($urandom_range(0, 5))
         0: s = "-";
         1: s = "+";
         default: s = "";
      endcase
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(18, 24) : $urandom_range(1, 5);
      for (int i = 0; i < n; i++) s = {s, byte'("0" + $urandom_range(0, 9))};
      return s;
   endfunction

   function automatic string rand_hash();
      string s, hx;
      hx = "0123456789abcdefABCDEF";
      s = "";
      for (int i = 0; i < 2 * HBYTES; i++) s = {s, hx[$urandom_range(0, 21)]};
      return s;
   endfunction

   task automatic send_line();
      int nf;
      int brk;
      string s;
      nf = hash_mode ? 8 : 10;
      brk = $urandom_range(0, 9);
      s = rand_name();
      for (int i = 0; i < nf; i++) s = {s, " ", rand_num()};
      if ((chk_req || hash_mode) && $urandom_range(0, 2) != 0)
         s = {s, " ", rand_hash(), " ", rand_hash()};
      if (brk == 0) begin
         // Damage one byte of the line with random junk.
         int p;
         p = $urandom_range(0, s.len() - 1);
         s[p] = $urandom_range(0, 255);
         if (s[p] == 8'd10) s[p] = 8'd0;
      end else if (brk == 1) s = s.substr(0, $urandom_range(0, s.len() - 1));
      send_text({s, "\n"});
   endtask

   // Directed table: line text and the expected line status.
   typedef struct {
      string txt;
      int status;
   } line_row;

   line_row dir_lines[$];

   initial begin
      string longname, h;
      clear_line();
      chk_req = 0; hash_mode = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      h = "";
      for (int i = 0; i < 2 * HBYTES; i++) h = {h, (i % 2) ? "F" : "a"};
      dir_lines = '{
         '{"a 1 2 3 4 5 6 7 8 9 10\n", ST_OK},
         '{"x\\ y 0 18446744073709551615 9223372036854775807 -9223372036854775808 -1 5 6 7 8 9\n", ST_OK},
         '{"o 99999999999999999999 99999999999999999999 -99999999999999999999 0 -5 +1 1 1 1 1\n", ST_OK},
         '{"e 1 2  3\n", ST_SYN},
         '{"e 1 2\n", ST_SYN},
         '{"n\\\n", ST_SYN},
         '{"\n", ST_SYN},
         '{"z\000 1\n", ST_SYN},
         '{"a 1 2 3 4 5 6 7 8 9 10 \n", ST_SYN},
         '{"q 1 x\n", ST_SYN},
         '{"h 1 2 3 4 5 6 7 8 - 10\n", ST_SYN}
      };
      foreach (dir_lines[i]) begin
         send_text(dir_lines[i].txt);
         drain();
         if (last_status !== dir_lines[i].status[1:0]) begin
            mismatches++;
            if (mismatches <= 10)
               $display("line %0d: expected status %0d, got %0d", i,
                        dir_lines[i].status, last_status);
         end
      end

      // Hash mode with both hashes, junk after the first or second hash, and no hash.
      write_reg(CSR_HASHMODE, 1'b1);
      send_text({"h 1 2 3 4 5 6 7 8 ", h, " ", h, "\n"});
      send_text({"h 1 2 3 4 5 6 7 8 ", h, "g\n"});
      send_text({"h 1 2 3 4 5 6 7 8 ", h, " ", h, "x\n"});
      send_text("h 1 2 3 4 5 6 7 8\n");
      drain();
      write_reg(CSR_CHECKSUM, 1'b1);
      send_text("h 1 2 3 4 5 6 7 8\n");
      drain();

      // Longest filename, then a backslash where one byte too many would go.
      longname = "";
      for (int i = 0; i < NAME_MAX; i++) longname = {longname, "n"};
      write_reg(CSR_CHECKSUM, 1'b0);
      write_reg(CSR_HASHMODE, 1'b0);
      send_text({longname, "\\n\n"});
      drain();

      // Random lines under all four register settings.
      for (int cfg = 0; cfg < 4; cfg++) begin
         write_reg(CSR_CHECKSUM, cfg[0]);
         write_reg(CSR_HASHMODE, cfg[1]);
         for (int i = 0; i < 3; i++) send_line();
         if (cfg == 3) drain();
         for (int i = 0; i < 4; i++) begin
            if ($urandom_range(0, 9) == 0) send_byte($urandom_range(0, 255));
            else send_line();
         end
         drain();
      end
      // Byte-noise stretch: random bytes with occasional newlines, then a final newline.
      for (int i = 0; i < 200; i++) send_byte(($urandom_range(0, 9) == 0) ? 8'd10
                                                : $urandom_range(0, 255));
      send_byte(8'd10);
      drain();

      $display("Sent %0d bytes in directed and random lines; checked %0d words, %0d lines.",
               bytes_sent, words_seen, lines_seen);
      if (mismatches == 0 && expected_words.size() == 0) begin
         $display("[metadata_line_parser_core] OK");
      end else begin
         $display("%0d mismatches, %0d words missing", mismatches, expected_words.size());
         $display("[metadata_line_parser_core] ERROR");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #20ms;
      $display("[metadata_line_parser_core] ERROR");
      $finish;
   end
endmodule
`default_nettype wire

@@ filelist.f @@
sv/mlp_pkg.sv
sv/mlp_front.sv
sv/mlp_back.sv
sv/metadata_line_parser_core.sv
bench/tb_metadata_line_parser_core.sv
